FILE: sv/lz77_token_decoder_assert.svh
// Assertion macros shared by the LZ77 token decoder RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef LZ77_TOKEN_DECODER_ASSERT_SVH
`define LZ77_TOKEN_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lz77_token_decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lz77_token_decoder: next-cycle check failed");

`endif

FILE: sv/ltd_pkg.sv
// Shared types and constants of the LZ77 token decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ltd_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 512;
    localparam int DEFAULT_MAX_MATCH    = 127;
    localparam int DEFAULT_LANES        = 4;

    // Fixed field widths of the token and result formats.
    localparam int OFF_W       = 9;
    localparam int LEN_W       = 7;
    localparam int LANE_CNT_W  = 3;
    localparam int FIELD_LANES = 4;
    // Wide enough for a copy distance of the largest supported window (4096).
    localparam int DIST_W      = 13;

    // Classified token, as handed from the front end to the byte engine.
    typedef struct packed {
        logic              frame_start;
        logic              src_ok;      // offset lies inside the window
        logic              near;        // copy distance of one byte
        logic [DIST_W-1:0] copy_dist;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;      // already clipped to the maximum match
        logic [7:0]        literal;
    } ltd_cmd_t;

    // One decoded byte on its way to the lane packer.
    typedef struct packed {
        logic [7:0] data;
        logic       last;               // the token's literal byte
    } ltd_beat_t;

    // One packed result.
    typedef struct packed {
        logic [FIELD_LANES-1:0][7:0] lanes;
        logic [LANE_CNT_W-1:0]       count;
        logic                        done;
    } ltd_result_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

endpackage

`default_nettype wire

FILE: sv/ltd_front.sv
// Front end of the LZ77 token decoder: classifies an incoming token.
// Depends on ltd_pkg for the command type and field widths.
`default_nettype none

module ltd_front #(
    parameter int WINDOW_DEPTH = ltd_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int MAX_MATCH    = ltd_pkg::DEFAULT_MAX_MATCH
) (
    input  wire logic                       frame_start,
    input  wire logic [ltd_pkg::OFF_W-1:0]  match_offset,
    input  wire logic [ltd_pkg::LEN_W-1:0]  match_length,
    input  wire logic [7:0]                 literal_byte,
    output ltd_pkg::ltd_cmd_t               cmd
);

    localparam int DIST_W = ltd_pkg::DIST_W;

    logic [DIST_W-1:0] offset_ext;

    assign offset_ext = DIST_W'(match_offset);

    always_comb
    begin
        cmd.frame_start = frame_start;
        cmd.offset      = match_offset;
        cmd.literal     = literal_byte;
        // An offset outside a small window has no source: every copied byte is zero.
        cmd.src_ok      = (offset_ext < DIST_W'(WINDOW_DEPTH));
        cmd.copy_dist   = cmd.src_ok ? (DIST_W'(WINDOW_DEPTH) - offset_ext) : '0;
        cmd.near        = cmd.src_ok && (offset_ext == DIST_W'(WINDOW_DEPTH - 1));
        if (9'(match_length) > 9'(MAX_MATCH))
        begin
            cmd.length = ltd_pkg::LEN_W'(MAX_MATCH);
        end
        else
        begin
            cmd.length = match_length;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ltd_cmd_queue.sv
// Two-entry command queue between the front end and the byte engine.
// Depends on ltd_pkg for the command type.
`default_nettype none

module ltd_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  ltd_pkg::ltd_cmd_t  push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output ltd_pkg::ltd_cmd_t  head_cmd
);

    ltd_pkg::ltd_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ltd_back.sv
// Byte engine of the LZ77 token decoder: sequences copy and literal bytes,
// owns the history window memory. Depends on ltd_pkg.
`default_nettype none

module ltd_back #(
    parameter int WINDOW_DEPTH = ltd_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  ltd_pkg::ltd_cmd_t  cmd,
    output logic               cmd_pop,
    output logic               beat_valid,
    output ltd_pkg::ltd_beat_t beat,
    input  wire logic          beat_ready
);

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int OFF_W  = ltd_pkg::OFF_W;
    localparam int DIST_W = ltd_pkg::DIST_W;
    localparam int SUM_W  = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;
    localparam int REM_W  = ltd_pkg::LEN_W + 1;

    logic [7:0] hist_mem [WINDOW_DEPTH];

    // Sequencer registers.
    ltd_pkg::seq_state_t state_reg, state_next;
    ltd_pkg::ltd_cmd_t   cmd_reg, cmd_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Read stage registers.
    logic             b_valid_reg, b_valid_next;
    logic             b_lit_reg;
    logic             b_zero_reg;
    logic             b_near_reg;
    logic [7:0]       b_literal_reg;
    logic [PTR_W-1:0] b_waddr_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       last_byte_reg;

    logic             b_ready, adv, is_lit, load, src_zero;
    logic [SUM_W-1:0] src_sum, src_wrap;
    logic [PTR_W-1:0] src_addr, wp_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       beat_data;

    assign b_ready = !b_valid_reg || beat_ready;
    assign adv     = (state_reg == ltd_pkg::SEQ_RUN) && b_ready;
    assign is_lit  = (rem_reg == REM_W'(1));

    // Source slot is write pointer minus distance, i.e. pointer plus offset, modulo the window.
    assign src_sum  = SUM_W'(wp_reg) + SUM_W'(cmd_reg.offset);
    assign src_wrap = (src_sum >= SUM_W'(WINDOW_DEPTH)) ? (src_sum - SUM_W'(WINDOW_DEPTH))
                                                        : src_sum;
    assign src_addr = src_wrap[PTR_W-1:0];
    assign src_zero = !cmd_reg.src_ok || (cmd_reg.copy_dist > DIST_W'(cnt_reg));

    assign wp_inc  = (wp_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : (wp_reg + PTR_W'(1));
    assign cnt_inc = (cnt_reg == CNT_W'(WINDOW_DEPTH)) ? cnt_reg : (cnt_reg + CNT_W'(1));

    // A distance of one refers to the byte leaving the read stage in the same cycle as the
    // read, so it is taken from the last emitted byte instead of the memory.
    always_comb
    begin
        if (b_lit_reg)
        begin
            beat_data = b_literal_reg;
        end
        else if (b_zero_reg)
        begin
            beat_data = 8'h00;
        end
        else if (b_near_reg)
        begin
            beat_data = last_byte_reg;
        end
        else
        begin
            beat_data = rd_data_reg;
        end
    end

    assign beat_valid = b_valid_reg;
    assign beat.data  = beat_data;
    assign beat.last  = b_lit_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        rem_next     = rem_reg;
        wp_next      = wp_reg;
        cnt_next     = cnt_reg;
        b_valid_next = b_valid_reg;
        load         = 1'b0;
        cmd_pop      = 1'b0;

        if (adv)
        begin
            rem_next     = rem_reg - REM_W'(1);
            wp_next      = wp_inc;
            cnt_next     = cnt_inc;
            b_valid_next = 1'b1;
        end
        else if (beat_ready)
        begin
            b_valid_next = 1'b0;
        end

        unique case (state_reg)
            ltd_pkg::SEQ_IDLE:
            begin
                load = cmd_valid;
            end
            ltd_pkg::SEQ_RUN:
            begin
                if (adv && is_lit)
                begin
                    if (cmd_valid)
                    begin
                        load = 1'b1;
                    end
                    else
                    begin
                        state_next = ltd_pkg::SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ltd_pkg::SEQ_IDLE;
            end
        endcase

        if (load)
        begin
            cmd_pop    = 1'b1;
            state_next = ltd_pkg::SEQ_RUN;
            cmd_next   = cmd;
            rem_next   = REM_W'(cmd.length) + REM_W'(1);
            if (cmd.frame_start)
            begin
                wp_next  = '0;
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ltd_pkg::SEQ_IDLE;
            rem_reg     <= '0;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            wp_reg      <= wp_next;
            cnt_reg     <= cnt_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (adv)
        begin
            b_lit_reg     <= is_lit;
            b_zero_reg    <= src_zero;
            b_near_reg    <= cmd_reg.near;
            b_literal_reg <= cmd_reg.literal;
            b_waddr_reg   <= wp_reg;
            rd_data_reg   <= hist_mem[src_addr];
        end
        if (b_valid_reg && beat_ready)
        begin
            hist_mem[b_waddr_reg] <= beat_data;
            last_byte_reg         <= beat_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ltd_packer.sv
// Lane packer of the LZ77 token decoder: gathers bytes into results and
// queues them for the output side. Depends on ltd_pkg.
`default_nettype none

module ltd_packer #(
    parameter int LANES = ltd_pkg::DEFAULT_LANES
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           beat_valid,
    input  ltd_pkg::ltd_beat_t  beat,
    output logic                beat_ready,
    input  wire logic           pop,
    output logic                empty,
    output ltd_pkg::ltd_result_t result
);

    localparam int FIELD_LANES = ltd_pkg::FIELD_LANES;
    localparam int CW          = ltd_pkg::LANE_CNT_W;
    localparam int EFF_LANES   = (LANES > FIELD_LANES) ? FIELD_LANES
                                                       : ((LANES < 1) ? 1 : LANES);

    logic [FIELD_LANES-1:0][7:0] acc_reg, acc_next;
    logic [CW-1:0]               acc_n_reg, acc_n_next;
    logic                        complete_reg, complete_next;
    logic                        done_reg, done_next;

    ltd_pkg::ltd_result_t out_reg [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           count_reg;

    logic          flush, take, base_empty, do_pop;
    logic [CW-1:0] base_n, new_n;

    assign flush      = complete_reg && (count_reg != 2'd2);
    assign beat_ready = !complete_reg || flush;
    assign take       = beat_valid && beat_ready;
    assign base_empty = complete_reg || (acc_n_reg == '0);
    assign base_n     = base_empty ? '0 : acc_n_reg;
    assign new_n      = base_n + CW'(1);
    assign empty      = (count_reg == 2'd0);
    assign do_pop     = pop && !empty;
    assign result     = out_reg[rd_ptr_reg];

    always_comb
    begin
        acc_next      = acc_reg;
        acc_n_next    = acc_n_reg;
        complete_next = complete_reg;
        done_next     = done_reg;
        if (flush)
        begin
            acc_n_next    = '0;
            complete_next = 1'b0;
        end
        if (take)
        begin
            for (int k = 0; k < FIELD_LANES; k++)
            begin
                if (CW'(k) == base_n)
                begin
                    acc_next[k] = beat.data;
                end
                else if (base_empty)
                begin
                    acc_next[k] = 8'h00;
                end
            end
            acc_n_next    = new_n;
            complete_next = beat.last || (new_n == CW'(EFF_LANES));
            done_next     = beat.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_n_reg    <= '0;
            complete_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            acc_n_reg    <= acc_n_next;
            complete_reg <= complete_next;
            if (flush)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(flush) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        done_reg <= done_next;
        if (flush)
        begin
            out_reg[wr_ptr_reg].lanes <= acc_reg;
            out_reg[wr_ptr_reg].count <= acc_n_reg;
            out_reg[wr_ptr_reg].done  <= done_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lz77_token_decoder.sv
// Throughput: one byte per cycle while the lane packer accepts bytes, so a token of copy
// length L makes the engine emit L + 1 bytes (up to 128); a token that finds the engine idle
// is loaded into it first, and a token already waiting in the command queue follows with
// no gap.
// Reset (rst_n, asynchronous, active low) empties both queues and starts an empty frame;
// the history memory is not cleared, as the produced-byte count gates every read of it.
`default_nettype none

// Top level of the LZ77 token decoder.
// Depends on ltd_pkg, ltd_front, ltd_cmd_queue, ltd_back, ltd_packer and the assert header.
module lz77_token_decoder #(
    parameter int WINDOW_DEPTH = ltd_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int MAX_MATCH    = ltd_pkg::DEFAULT_MAX_MATCH,
    parameter int LANES        = ltd_pkg::DEFAULT_LANES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Token side: a transaction completes when push is high and full is low.
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            frame_start,
    input  wire logic [ltd_pkg::OFF_W-1:0]       match_offset,
    input  wire logic [ltd_pkg::LEN_W-1:0]       match_length,
    input  wire logic [7:0]                      literal_byte,
    // Result side: a transaction completes when pop is high and empty is low.
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [7:0]                           byte_lane0,
    output logic [7:0]                           byte_lane1,
    output logic [7:0]                           byte_lane2,
    output logic [7:0]                           byte_lane3,
    output logic [ltd_pkg::LANE_CNT_W-1:0]       lane_count,
    output logic                                 token_done
);

    localparam int EFF_LANES = (LANES > ltd_pkg::FIELD_LANES) ? ltd_pkg::FIELD_LANES
                                                              : ((LANES < 1) ? 1 : LANES);
    localparam int CW        = ltd_pkg::LANE_CNT_W;

    ltd_pkg::ltd_cmd_t    front_cmd;
    ltd_pkg::ltd_cmd_t    head_cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;
    logic                 beat_valid;
    logic                 beat_ready;
    ltd_pkg::ltd_beat_t   beat;
    ltd_pkg::ltd_result_t result;
    logic                 count_in_range;

    // The front end works out everything that depends only on the token itself: the copy
    // distance, whether the offset has a source at all, whether the distance is a single
    // byte (which needs forwarding in the engine), and the length clipped to the maximum.
    ltd_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_MATCH    (MAX_MATCH)
    ) u_front (
        .frame_start  (frame_start),
        .match_offset (match_offset),
        .match_length (match_length),
        .literal_byte (literal_byte),
        .cmd          (front_cmd)
    );

    // The command queue decouples token intake from byte generation, so the next token is
    // taken in while the engine is still expanding the current one.
    ltd_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .head_cmd  (head_cmd)
    );

    // The engine walks a token one byte per cycle unless the packer stalls it. Its first stage
    // picks the source slot and decides whether the byte reads as zero (source before the frame
    // start or outside the window); its second stage holds the registered memory read, resolves
    // the byte and writes it back into the history, so overlapping copies repeat bytes.
    ltd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (head_cmd),
        .cmd_pop    (cmd_pop),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_ready (beat_ready)
    );

    // The packer collects bytes into results of up to EFF_LANES lanes, closing a result
    // early on the literal, and queues up to two finished results, so the engine stops only
    // when that queue is full and a further result is complete.
    ltd_packer #(
        .LANES (LANES)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_ready (beat_ready),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    assign byte_lane0 = result.lanes[0];
    assign byte_lane1 = result.lanes[1];
    assign byte_lane2 = result.lanes[2];
    assign byte_lane3 = result.lanes[3];
    assign lane_count = result.count;
    assign token_done = result.done;

    assign count_in_range = (lane_count != '0) && (lane_count <= CW'(EFF_LANES));

`include "lz77_token_decoder_assert.svh"

    // A waiting result always carries between one and the configured number of lanes.
    `LTD_ASSERT_SAME(a_lane_count_range, !empty, count_in_range)
    // Only the result holding the literal may be shorter than a full result.
    `LTD_ASSERT_SAME(a_short_is_done, !empty && (lane_count != CW'(EFF_LANES)), token_done)
    // The engine takes a command only when the queue holds one.
    `LTD_ASSERT_SAME(a_pop_needs_cmd, cmd_pop, cmd_valid)
    // A command taken from a full queue frees a slot on the next cycle.
    `LTD_ASSERT_NEXT(a_queue_drains, full && cmd_pop && !push, !full)

endmodule

`default_nettype wire

FILE: tb/lz77_token_decoder_tb.sv
// Self-checking testbench for the LZ77 token decoder: directed tokens, then random frames.
// Depends on ltd_pkg and the lz77_token_decoder top level; the expected bytes come from
// a behavioral copy of the history window kept here.
`default_nettype none

module lz77_token_decoder_tb;

    import ltd_pkg::*;

    localparam int WINDOW    = DEFAULT_WINDOW_DEPTH;
    localparam int MAX_LEN   = DEFAULT_MAX_MATCH;
    localparam int WORD_BYTES = (DEFAULT_LANES > FIELD_LANES) ? FIELD_LANES : DEFAULT_LANES;

    // The slowest legal run is far below this: every token expanding to 32 words, each
    // word waiting out the longest receiver stall, plus every sender gap.
    localparam int CYCLE_LIMIT = 1500000;

    // Receiver behavior, picked anew at random whenever the current mode runs out.
    typedef enum logic [1:0] {
        POP_STEADY,   // pop every cycle
        POP_COIN,     // pop on a coin toss
        POP_BURSTY    // mostly pop, with occasional long stalls
    } pop_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       push = 1'b0;
    logic       full;
    logic       frame_start = 1'b0;
    logic [OFF_W-1:0] match_offset = '0;
    logic [LEN_W-1:0] match_length = '0;
    logic [7:0] literal_byte = '0;

    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] byte_lane0;
    logic [7:0] byte_lane1;
    logic [7:0] byte_lane2;
    logic [7:0] byte_lane3;
    logic [LANE_CNT_W-1:0] lane_count;
    logic       token_done;

    lz77_token_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .frame_start  (frame_start),
        .match_offset (match_offset),
        .match_length (match_length),
        .literal_byte (literal_byte),
        .empty        (empty),
        .pop          (pop),
        .byte_lane0   (byte_lane0),
        .byte_lane1   (byte_lane1),
        .byte_lane2   (byte_lane2),
        .byte_lane3   (byte_lane3),
        .lane_count   (lane_count),
        .token_done   (token_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral history window. It mirrors the decoder's state: the byte
    // memory, the next slot to write and the count of bytes decoded in the
    // current frame, which saturates at the window depth.
    // ------------------------------------------------------------------
    logic [7:0]  window_mem [WINDOW];
    int unsigned wr_slot;
    int unsigned frame_bytes;

    // Words the decoder still owes us, oldest first.
    ltd_result_t expected_words [$];

    int errors = 0;
    int unsigned cycle_count = 0;
    bit drain;

    // Expands one token into its decoded bytes, updates the window, and
    // queues the packed words that the decoder must produce for it.
    function automatic void predict_token(input logic fs, input logic [OFF_W-1:0] off,
                                          input logic [LEN_W-1:0] len,
                                          input logic [7:0] lit);
        logic [7:0]  decoded [$];
        logic [7:0]  b;
        int unsigned copy_dist;
        int unsigned run_len;
        int unsigned n;
        int          j;
        int          pos;
        int          k;
        ltd_result_t word;

        if (fs)
        begin
            wr_slot     = 0;
            frame_bytes = 0;
        end
        run_len = (len > MAX_LEN) ? MAX_LEN : len;
        // Offset WINDOW-1 is the newest byte, so the distance back is WINDOW - offset.
        copy_dist = (off < WINDOW) ? (WINDOW - off) : 0;

        for (j = 0; j <= run_len; j++)
        begin
            if (j == run_len)
                b = lit;
            else if (copy_dist == 0 || copy_dist > frame_bytes)
                b = 8'h00;   // reaches before the frame start or past the window
            else
                b = window_mem[(wr_slot + WINDOW - copy_dist) % WINDOW];
            // Every byte enters the window at once, which yields the overlap copy.
            window_mem[wr_slot] = b;
            wr_slot = (wr_slot + 1) % WINDOW;
            if (frame_bytes < WINDOW)
                frame_bytes++;
            decoded.push_back(b);
        end

        for (pos = 0; pos < decoded.size(); pos += WORD_BYTES)
        begin
            n = decoded.size() - pos;
            if (n > WORD_BYTES)
                n = WORD_BYTES;
            word = '0;
            for (k = 0; k < n; k++)
                word.lanes[k] = decoded[pos + k];
            word.count = n[LANE_CNT_W-1:0];
            word.done  = (pos + n >= decoded.size());
            expected_words.push_back(word);
        end
    endfunction

    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Token side. send_token raises push with the token and holds it until
    // a clock edge sees full low; that edge completes the transaction and
    // the token is handed to the predictor. push stays high so that the
    // next call continues back to back; only idle_sender lowers it.
    // ------------------------------------------------------------------
    task automatic send_token(input logic fs, input logic [OFF_W-1:0] off,
                              input logic [LEN_W-1:0] len, input logic [7:0] lit);
        push         <= 1'b1;
        frame_start  <= fs;
        match_offset <= off;
        match_length <= len;
        literal_byte <= lit;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_token(fs, off, len, lit);
    endtask

    task automatic idle_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side. At each edge a completed transaction is compared field by
    // field against the oldest expected word. pop then gets its next value
    // from a stall pattern that is independent of the sender's bursts, so
    // the result queue fills up and backs pressure into full.
    // ------------------------------------------------------------------
    pop_mode_t pop_mode = POP_STEADY;
    int unsigned mode_left = 0;
    int unsigned stall_left = 0;
    ltd_result_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, %s %h %h %h %h %s %0d %0d",
                         $time, "actual lanes", byte_lane0, byte_lane1, byte_lane2,
                         byte_lane3, "count/done", lane_count, token_done);
            end
            else
            begin
                oldest = expected_words.pop_front();
                report_field("byte_lane0", 32'(oldest.lanes[0]), 32'(byte_lane0));
                report_field("byte_lane1", 32'(oldest.lanes[1]), 32'(byte_lane1));
                report_field("byte_lane2", 32'(oldest.lanes[2]), 32'(byte_lane2));
                report_field("byte_lane3", 32'(oldest.lanes[3]), 32'(byte_lane3));
                report_field("lane_count", 32'(oldest.count), 32'(lane_count));
                report_field("token_done", 32'(oldest.done), 32'(token_done));
            end
        end

        if (mode_left == 0)
        begin
            pop_mode  = pop_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 300);
        end
        else
            mode_left--;

        if (drain)
            pop <= 1'b1;
        else if (stall_left != 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else
        begin
            case (pop_mode)
                POP_STEADY: pop <= 1'b1;
                POP_COIN:   pop <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        pop <= 1'b0;
                        stall_left = $urandom_range(1, 12);
                    end
                    else
                        pop <= 1'b1;
                end
            endcase
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Tokens before any frame start decode from the empty reset frame, so a
    // copy reaching back before reset reads as zero. Includes an overlap copy
    // over the token's own bytes and a literal-only token.
    task automatic test_no_frame_start();
        send_token(1'b0, 9'd511, 7'd3, 8'hA5);
        send_token(1'b0, 9'd511, 7'd0, 8'h5A);
        send_token(1'b0, 9'd510, 7'd5, 8'h11);
        idle_sender(3);
    endtask

    // A frame start drops the history, so an offset that was valid a moment
    // ago now lies before the first byte of the frame and reads as zero.
    task automatic test_frame_restart();
        send_token(1'b1, 9'd511, 7'd2, 8'hFF);
        send_token(1'b0, 9'd0, 7'd0, 8'h00);
        send_token(1'b0, 9'd0, 7'd0, 8'h80);
        send_token(1'b0, 9'd0, 7'd1, 8'h7F);
        send_token(1'b0, 9'd508, 7'd127, 8'h3C);
        idle_sender(2);
    endtask

    // Fills the whole window, then copies from its oldest and newest slots
    // with the longest match.
    task automatic test_window_extremes();
        send_token(1'b1, 9'd0, 7'd0, 8'h21);
        send_token(1'b0, 9'd511, 7'd127, 8'h43);
        send_token(1'b0, 9'd510, 7'd127, 8'h65);
        send_token(1'b0, 9'd505, 7'd127, 8'h87);
        send_token(1'b0, 9'd400, 7'd127, 8'hA9);
        send_token(1'b0, 9'd0, 7'd127, 8'hCB);
        send_token(1'b0, 9'd1, 7'd20, 8'hED);
        send_token(1'b0, 9'd511, 7'd127, 8'h00);
        send_token(1'b0, 9'd256, 7'd64, 8'h96);
        idle_sender(1);
    endtask

    // Frames of random size. Most copies point at bytes already decoded in
    // the frame or close to the newest one; the rest use any offset, which
    // also reaches before the frame start. Frame starts also land mid-stream.
    task automatic test_random_frames(input int count);
        int          sent;
        int          burst_left;
        int unsigned pick;
        int unsigned reach;
        logic        fs;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;

        burst_left = 0;
        for (sent = 0; sent < count; sent++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;

            fs = (sent == 0) || ($urandom_range(0, 24) == 0);

            // Mostly short matches so that the run stays quick.
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = LEN_W'($urandom_range(0, 12));
            else if (pick < 90)
                len = LEN_W'($urandom_range(13, 60));
            else
                len = LEN_W'($urandom_range(61, 127));

            reach = fs ? 0 : frame_bytes;
            pick  = $urandom_range(0, 99);
            if (pick < 40)
                off = OFF_W'(WINDOW - 1 - $urandom_range(0, 7));
            else if (pick < 75 && reach > 0)
                off = OFF_W'(WINDOW - $urandom_range(1, reach));
            else
                off = OFF_W'($urandom_range(0, WINDOW - 1));

            send_token(fs, off, len, 8'($urandom_range(0, 255)));
        end
        idle_sender(1);
    endtask

    initial
    begin
        drain       = 1'b0;
        wr_slot     = 0;
        frame_bytes = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_frame_start();
        test_frame_restart();
        test_window_extremes();
        test_random_frames(350);

        // Let the receiver take everything, then watch for stray results.
        drain = 1'b1;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
